>>> rtl/srtc_pkg.sv
package srtc_pkg;

	// Tile geometry and size limits.
	localparam int unsigned TILE_SIZE        = 16;
	localparam int unsigned TILE_BITS        = $clog2(TILE_SIZE);
	localparam int unsigned MAX_WIDTH        = 4096;
	localparam int unsigned MAX_TILE_COLUMNS = 256;
	localparam int unsigned HEIGHT_LIMIT     = 4096;
	localparam int unsigned WIDTH_CAP        =
		(MAX_WIDTH < MAX_TILE_COLUMNS * TILE_SIZE) ? MAX_WIDTH : MAX_TILE_COLUMNS * TILE_SIZE;

	// Field widths.
	localparam int unsigned POS_W  = 12;
	localparam int unsigned CFG_W  = 13;
	localparam int unsigned PCT_W  = 7;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned ADDR_W = $clog2(MAX_TILE_COLUMNS);
	localparam int unsigned TILE_W = 8;
	localparam int unsigned CNT_W  = $clog2(TILE_SIZE * TILE_SIZE + 1);
	localparam int unsigned PROD_W = CNT_W + PCT_W;

	localparam int unsigned PCT_SCALE = 100;

	// Register indexes of the configuration port.
	typedef enum logic [IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_DENSE_PCT    = 3'd2,
		CFG_EDGE_PCT     = 3'd3
	} cfg_idx_t;

	// Shading-rate codes.
	typedef enum logic [1:0] {
		RATE_EMPTY  = 2'd0,
		RATE_FULL   = 2'd1,
		RATE_COARSE = 2'd2
	} rate_t;

	// Per-column tile counters, stored as one memory word.
	typedef struct packed {
		logic [CNT_W-1:0] pix;
		logic [CNT_W-1:0] cov;
		logic [CNT_W-1:0] edg;
	} cnt_t;

	// Where the current pixel falls, as seen by the raster tracker.
	typedef struct packed {
		logic [ADDR_W-1:0] col;
		logic [TILE_W-1:0] row;
		logic              tile_done;
		logic              last;
		logic              first;
	} pix_info_t;

	// A finished tile handed to the classifier.
	typedef struct packed {
		logic [TILE_W-1:0] col;
		logic [TILE_W-1:0] row;
		logic              last;
		cnt_t              cnt;
	} cls_req_t;

	// Last valid coordinate for a written size: zero counts as one and the
	// size is clamped to the given cap.
	function automatic logic [POS_W-1:0] eff_last(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] cap);
		logic [CFG_W-1:0] t;
		begin
			if (v == '0) begin
				t = CFG_W'(1);
			end else if (v > cap) begin
				t = cap;
			end else begin
				t = v;
			end
			return POS_W'(t - CFG_W'(1));
		end
	endfunction

endpackage

>>> rtl/shading_rate_tile_classifier.sv
// Channel  Handshake            Payload                                    Direction
// input    in_valid/in_ready    covered, edge_flag                         into block
// result   out_valid/out_ready  tile_col, tile_row, rate_code, last_tile   out of block
// config   cfg_valid/cfg_ready  cfg_index, cfg_data                        into block
//
// One pixel is taken every cycle while the input is not stalled; on its way to a result
// a pixel passes a counter read, a read-modify-write of the column entry and classification
// into the output register. The rate is set by the single read-modify-write of the column counter memory.
// Reset clears the position, the pipeline valid bits and loads the default image size and
// thresholds; no clearing pass is needed. Input stalls only while a finished tile waits in
// the classify stage and the output register is not taken.
module shading_rate_tile_classifier
	import srtc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              covered,
	input  logic              edge_flag,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TILE_W-1:0] tile_col,
	output logic [TILE_W-1:0] tile_row,
	output logic [1:0]        rate_code,
	output logic              last_tile,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	// Configuration registers. The image size is stored as its last coordinate,
	// already clamped, so the raster tracker only compares for equality.
	logic [POS_W-1:0] width_last_q;
	logic [POS_W-1:0] height_last_q;
	logic [PCT_W-1:0] dense_pct_q;
	logic [PCT_W-1:0] edge_pct_q;
	logic             cfg_write;
	logic             restart;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign restart   = cfg_write &&
		(cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_last_q  <= POS_W'(1919);
			height_last_q <= POS_W'(1079);
			dense_pct_q   <= PCT_W'(85);
			edge_pct_q    <= PCT_W'(3);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					width_last_q <= eff_last(cfg_data, CFG_W'(WIDTH_CAP));
				end
				CFG_IMAGE_HEIGHT: begin
					height_last_q <= eff_last(cfg_data, CFG_W'(HEIGHT_LIMIT));
				end
				CFG_DENSE_PCT: begin
					dense_pct_q <= cfg_data[PCT_W-1:0];
				end
				CFG_EDGE_PCT: begin
					edge_pct_q <= cfg_data[PCT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front end: raster position of the pixel now offered.
	logic      accept;
	logic      advance;
	pix_info_t pix;

	assign in_ready = advance;
	assign accept   = in_valid && in_ready;

	srtc_raster u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.width_last  (width_last_q),
		.height_last (height_last_q),
		.restart     (restart),
		.advance     (accept),
		.pix         (pix)
	);

	// Stage 1: the counter entry of the pixel's column is read at the transfer edge
	// and updated here. The first pixel of a tile starts from zero, which stands in
	// for clearing the entry after each tile and after reset or a size change. When
	// the previous pixel wrote the same column at the very edge this pixel read it,
	// the memory still shows the old word, so its new value is forwarded instead.
	logic      s1_valid_q;
	pix_info_t pix_s1;
	logic      covered_s1;
	logic      edge_s1;
	logic      fwd_s1;
	cnt_t      fwd_data_s1;
	cnt_t      rd_data;
	cnt_t      base;
	cnt_t      upd;
	logic      ram_we;
	cls_req_t  req;

	always_comb begin
		if (pix_s1.first) begin
			base = '0;
		end else if (fwd_s1) begin
			base = fwd_data_s1;
		end else begin
			base = rd_data;
		end
		upd.pix = base.pix + CNT_W'(1);
		upd.cov = base.cov + CNT_W'(covered_s1);
		upd.edg = base.edg + CNT_W'(edge_s1);
	end

	assign ram_we = s1_valid_q && advance;

	srtc_ram #(
		.DATA_W ($bits(cnt_t)),
		.DEPTH  (MAX_TILE_COLUMNS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pix_s1.col),
		.wdata (upd),
		.re    (accept),
		.raddr (pix.col),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pix;
			covered_s1  <= covered;
			edge_s1     <= edge_flag;
			fwd_s1      <= s1_valid_q && (pix_s1.col == pix.col);
			fwd_data_s1 <= upd;
		end
	end

	// A finished tile moves on to classification with its final counts.
	assign req.col  = TILE_W'(pix_s1.col);
	assign req.row  = pix_s1.row;
	assign req.last = pix_s1.last;
	assign req.cnt  = upd;

	rate_t out_rate;

	srtc_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.dense_pct (dense_pct_q),
		.edge_pct  (edge_pct_q),
		.req_valid (s1_valid_q && pix_s1.tile_done),
		.req       (req),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_col   (tile_col),
		.out_row   (tile_row),
		.out_rate  (out_rate),
		.out_last  (last_tile)
	);

	assign rate_code = out_rate;

	// The input is held back only by a blocked result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a blocked result");

	// The last pixel of an image is followed by the first pixel of a tile.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pix.last && !restart) |=> pix.first)
		else $error("position did not wrap after the last pixel");

	// Forwarding is only taken for a column written at the transfer edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !(s1_valid_q && pix_s1.col == pix.col)) |=> !fwd_s1)
		else $error("forwarding selected without a matching write");

	// A result never carries a code outside the defined rates.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rate_code == RATE_EMPTY || rate_code == RATE_FULL ||
			rate_code == RATE_COARSE))
		else $error("undefined rate code");

endmodule

>>> rtl/srtc_ram.sv
module srtc_ram #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/srtc_raster.sv
module srtc_raster
	import srtc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [POS_W-1:0] width_last,
	input  logic [POS_W-1:0] height_last,
	input  logic             restart,
	input  logic             advance,
	output pix_info_t        pix
);

	logic [POS_W-1:0] x_q;
	logic [POS_W-1:0] y_q;
	logic             row_end;
	logic             bottom;
	logic             col_end;
	logic             tile_row_end;

	assign row_end      = (x_q == width_last);
	assign bottom       = (y_q == height_last);
	assign col_end      = row_end || (x_q[TILE_BITS-1:0] == '1);
	assign tile_row_end = bottom || (y_q[TILE_BITS-1:0] == '1);

	assign pix.col       = x_q[POS_W-1:TILE_BITS];
	assign pix.row       = TILE_W'(y_q[POS_W-1:TILE_BITS]);
	assign pix.tile_done = col_end && tile_row_end;
	assign pix.last      = row_end && bottom;
	// The first pixel of a tile opens a fresh count for its column.
	assign pix.first     = (x_q[TILE_BITS-1:0] == '0) && (y_q[TILE_BITS-1:0] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (restart) begin
			x_q <= '0;
			y_q <= '0;
		end else if (advance) begin
			if (row_end) begin
				x_q <= '0;
				y_q <= bottom ? '0 : y_q + POS_W'(1);
			end else begin
				x_q <= x_q + POS_W'(1);
			end
		end
	end

endmodule

>>> rtl/srtc_classify.sv
module srtc_classify
	import srtc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PCT_W-1:0]  dense_pct,
	input  logic [PCT_W-1:0]  edge_pct,
	input  logic              req_valid,
	input  cls_req_t          req,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TILE_W-1:0] out_col,
	output logic [TILE_W-1:0] out_row,
	output rate_t             out_rate,
	output logic              out_last
);

	logic             s2_valid_q;
	cls_req_t         req_s2;
	logic             out_valid_q;
	logic [PROD_W-1:0] cov_scaled;
	logic [PROD_W-1:0] dense_need;
	logic [PROD_W-1:0] edg_scaled;
	logic [PROD_W-1:0] edge_allow;
	rate_t            rate;

	// The pipeline only holds when a tile waits here and the output is blocked.
	assign advance = !(s2_valid_q && out_valid_q && !out_ready);

	assign cov_scaled = PROD_W'(req_s2.cnt.cov) * PROD_W'(PCT_SCALE);
	assign dense_need = PROD_W'(dense_pct) * PROD_W'(req_s2.cnt.pix);
	assign edg_scaled = PROD_W'(req_s2.cnt.edg) * PROD_W'(PCT_SCALE);
	assign edge_allow = PROD_W'(edge_pct) * PROD_W'(req_s2.cnt.cov);

	always_comb begin
		if (req_s2.cnt.cov == '0) begin
			rate = RATE_EMPTY;
		end else if (cov_scaled < dense_need || edg_scaled > edge_allow) begin
			rate = RATE_FULL;
		end else begin
			rate = RATE_COARSE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				s2_valid_q <= req_valid;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid) begin
			req_s2 <= req;
		end
		if ((!out_valid_q || out_ready) && s2_valid_q) begin
			out_col  <= req_s2.col;
			out_row  <= req_s2.row;
			out_rate <= rate;
			out_last <= req_s2.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> bench/shading_rate_tile_classifier_tb.sv
module shading_rate_tile_classifier_tb
	import srtc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CLK_PERIOD       = 2;
	localparam int unsigned RESET_CYCLES     = 11;
	localparam int unsigned MAX_GAP          = 7;
	// The pipeline is three stages deep; the spare settle cycles cover pixels that
	// finish no tile but may still be in flight when the last tile arrives.
	localparam int unsigned SETTLE_CYCLES    = 8;
	localparam int unsigned HOLD_CYCLES      = 150;
	localparam int unsigned WATCHDOG_LIMIT   = 4000;
	localparam int unsigned RANDOM_ITEMS     = 1160;
	localparam int unsigned CLAMP_PIXELS     = 48;
	localparam int unsigned MAX_REPORTS      = 10;

	// One classified tile as it leaves the block.
	typedef struct packed {
		logic [TILE_W-1:0] col;
		logic [TILE_W-1:0] row;
		rate_t             rate;
		logic              last;
	} tile_result_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic              covered   = 1'b0;
	logic              edge_flag = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [TILE_W-1:0] tile_col;
	logic [TILE_W-1:0] tile_row;
	logic [1:0]        rate_code;
	logic              last_tile;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data  = '0;

	// Shadow copy of the block's registers, counters and raster position.
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	logic [PCT_W-1:0] dense_reg;
	logic [PCT_W-1:0] edge_reg;
	int unsigned      col_pixels  [MAX_TILE_COLUMNS];
	int unsigned      col_covered [MAX_TILE_COLUMNS];
	int unsigned      col_edges   [MAX_TILE_COLUMNS];
	int unsigned      pos_x;
	int unsigned      pos_y;

	// Tiles the shadow model has finished but the block has not yet delivered.
	tile_result_t expected_tiles[$];

	int unsigned mismatch_count = 0;

	// Knobs the tests turn: random idling on either side, and a one-shot
	// request for the result side to hold off for a long stretch.
	bit          sender_idles      = 1'b1;
	bit          receiver_idles    = 1'b1;
	int unsigned ready_hold_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	shading_rate_tile_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.covered   (covered),
		.edge_flag (edge_flag),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tile_col  (tile_col),
		.tile_row  (tile_row),
		.rate_code (rate_code),
		.last_tile (last_tile),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Shadow model of the tile classifier.
	// ------------------------------------------------------------------

	// A width of zero counts as one pixel, and the width can never exceed
	// what the column counters can hold.
	function automatic int unsigned frame_width();
		int unsigned w;
		w = width_reg;
		if (w == 0) w = 1;
		if (w > WIDTH_CAP) w = WIDTH_CAP;
		return w;
	endfunction

	function automatic int unsigned frame_height();
		int unsigned h;
		h = height_reg;
		if (h == 0) h = 1;
		if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
		return h;
	endfunction

	function automatic void restart_frame();
		for (int i = 0; i < MAX_TILE_COLUMNS; i++) begin
			col_pixels[i]  = 0;
			col_covered[i] = 0;
			col_edges[i]   = 0;
		end
		pos_x = 0;
		pos_y = 0;
	endfunction

	// Percent thresholds are compared by cross multiplication, so a tile
	// exactly at a threshold is neither below the coverage bound nor above
	// the edge bound.
	function automatic rate_t tile_rate(input int unsigned pix, input int unsigned cov,
		input int unsigned edg);
		if (cov == 0 || pix == 0) return RATE_EMPTY;
		if (cov * PCT_SCALE < dense_reg * pix) return RATE_FULL;
		if (edg * PCT_SCALE > edge_reg * cov) return RATE_FULL;
		return RATE_COARSE;
	endfunction

	function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		case (cfg_idx_t'(idx))
			CFG_IMAGE_WIDTH: begin
				width_reg = data;
				restart_frame();
			end
			CFG_IMAGE_HEIGHT: begin
				height_reg = data;
				restart_frame();
			end
			CFG_DENSE_PCT: dense_reg = data[PCT_W-1:0];
			CFG_EDGE_PCT:  edge_reg  = data[PCT_W-1:0];
			default: ;
		endcase
	endfunction

	// Accumulates one pixel into its column and, when it closes a tile,
	// queues the tile the block must report.
	function automatic void accumulate_pixel(input bit cov, input bit edg);
		int unsigned  w, h, x, y, col;
		bit           row_end, bottom, tile_done;
		tile_result_t tile;
		w = frame_width();
		h = frame_height();
		x = pos_x;
		y = pos_y;
		if (x >= w) x = 0;
		if (y >= h) y = 0;
		col = x / TILE_SIZE;
		if (col >= MAX_TILE_COLUMNS) col = MAX_TILE_COLUMNS - 1;
		col_pixels[col]++;
		if (cov) col_covered[col]++;
		if (edg) col_edges[col]++;
		row_end   = (x + 1 == w);
		bottom    = (y + 1 == h);
		tile_done = (row_end || x % TILE_SIZE == TILE_SIZE - 1) &&
			(bottom || y % TILE_SIZE == TILE_SIZE - 1);
		if (tile_done) begin
			tile.col  = TILE_W'(col);
			tile.row  = TILE_W'(y / TILE_SIZE);
			tile.rate = tile_rate(col_pixels[col], col_covered[col], col_edges[col]);
			tile.last = row_end && bottom;
			expected_tiles = {expected_tiles, tile};
			col_pixels[col]  = 0;
			col_covered[col] = 0;
			col_edges[col]   = 0;
		end
		if (row_end) begin
			x = 0;
			y = bottom ? 0 : y + 1;
		end else begin
			x = x + 1;
		end
		pos_x = x;
		pos_y = y;
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers.
	// ------------------------------------------------------------------

	// Offers one pixel and waits for its transfer. Valid is only dropped when
	// a gap is drawn, so back-to-back pixels keep it high without a glitch.
	task automatic send_pixel(input bit cov, input bit edg);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		covered   <= cov;
		edge_flag <= edg;
		do @(posedge clk); while (!in_ready);
		accumulate_pixel(cov, edg);
	endtask

	task automatic send_pixels(input int unsigned count, input int unsigned cov_pct,
		input int unsigned edge_pct);
		for (int unsigned i = 0; i < count; i++) begin
			send_pixel($urandom_range(0, 99) < cov_pct, $urandom_range(0, 99) < edge_pct);
		end
	endtask

	// Stops offering pixels and waits until every queued tile has come out,
	// plus SETTLE_CYCLES more for pixels that close no tile. Registers are only
	// written after this.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_tiles.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_image(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
	endtask

	task automatic set_thresholds(input logic [PCT_W-1:0] dense, input logic [PCT_W-1:0] edg);
		write_reg(CFG_DENSE_PCT, CFG_W'(dense));
		write_reg(CFG_EDGE_PCT, CFG_W'(edg));
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Reset values: the default 1920x1080 frame closes no tile within a few
	// pixels. Dropping the height to one row restarts the frame and turns
	// every 16 pixels into a tile, classified with the reset thresholds.
	task automatic test_reset_state();
		send_pixels(20, 50, 50);
		settle();
		write_reg(CFG_IMAGE_HEIGHT, CFG_W'(1));
		// Fully covered, no edges: coarse rate.
		send_pixels(16, 100, 0);
		// Nothing covered: empty tile.
		send_pixels(16, 0, 0);
		// One edge pixel out of sixteen is above the default edge share.
		send_pixel(1'b1, 1'b1);
		send_pixels(15, 100, 0);
	endtask

	// Zero sizes count as one. Oversize widths and heights are clamped; the
	// first tiles of a clamped one-row and a clamped one-column frame are
	// checked.
	task automatic test_size_limits();
		settle();
		set_image('0, '0);
		send_pixel(1'b0, 1'b0);
		send_pixel(1'b1, 1'b0);
		send_pixel(1'b1, 1'b1);
		settle();
		set_image('1, CFG_W'(1));
		send_pixels(CLAMP_PIXELS, 60, 10);
		settle();
		set_image(CFG_W'(1), '1);
		send_pixels(CLAMP_PIXELS, 60, 10);
	endtask

	// Threshold extremes on a small 4x2 image, two tiles per setting. A
	// dense threshold above 100 keeps every covered tile at full rate.
	task automatic test_threshold_extremes();
		settle();
		set_image(CFG_W'(4), CFG_W'(2));
		set_thresholds('0, '0);
		send_pixels(16, 75, 25);
		settle();
		set_thresholds(PCT_W'(PCT_SCALE), PCT_W'(PCT_SCALE));
		send_pixels(16, 100, 25);
		settle();
		set_thresholds('1, '1);
		send_pixels(16, 75, 75);
		settle();
		set_thresholds(PCT_W'(PCT_SCALE), '0);
		send_pixels(16, 100, 0);
	endtask

	// Writes to indexes past the last register must change nothing.
	task automatic test_unknown_index();
		settle();
		for (int i = int'(CFG_EDGE_PCT) + 1; i < (1 << IDX_W); i++) begin
			write_reg(IDX_W'(i), '1);
		end
		send_pixels(16, 75, 25);
	endtask

	// A one-pixel image makes every pixel a tile. The result side holds off
	// for a long stretch while pixels keep coming, so the block fills and
	// must stall its input; then the sender pauses until all tiles are out.
	task automatic test_output_backpressure();
		settle();
		set_image(CFG_W'(1), CFG_W'(1));
		sender_idles      = 1'b0;
		ready_hold_cycles = HOLD_CYCLES;
		send_pixels(40, 50, 50);
		settle();
		receiver_idles = 1'b0;
		send_pixels(30, 50, 50);
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
	endtask

	// Random phases: mostly small images with partial tiles, some with full
	// 16x16 tiles, a few very wide ones. Thresholds change sometimes without
	// a resize, so they land in the middle of a frame.
	task automatic test_random_frames();
		int unsigned items, count, cov_pct, edge_pct, shape;
		items = 0;
		while (items < RANDOM_ITEMS) begin
			settle();
			shape = $urandom_range(0, 7);
			if (shape == 0) begin
				set_image(CFG_W'($urandom_range(17, WIDTH_CAP)), CFG_W'($urandom_range(1, 2)));
			end else if (shape <= 2) begin
				set_image(CFG_W'($urandom_range(16, 40)), CFG_W'($urandom_range(16, 20)));
			end else if (shape <= 5) begin
				set_image(CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(1, 20)));
			end
			if ($urandom_range(0, 3) == 0) begin
				set_thresholds(PCT_W'($urandom_range(0, 1) * PCT_SCALE), '1);
			end else if ($urandom_range(0, 2) != 0) begin
				set_thresholds(PCT_W'($urandom_range(0, PCT_SCALE)),
					PCT_W'($urandom_range(0, PCT_SCALE)));
			end
			case ($urandom_range(0, 4))
				0: cov_pct = 0;
				1: cov_pct = 50;
				2: cov_pct = 85;
				3: cov_pct = 95;
				default: cov_pct = 100;
			endcase
			case ($urandom_range(0, 4))
				0: edge_pct = 0;
				1: edge_pct = 3;
				2: edge_pct = 10;
				3: edge_pct = 40;
				default: edge_pct = 100;
			endcase
			// Some phases run with no idling at all on one or both sides.
			sender_idles   = $urandom_range(0, 3) != 0;
			receiver_idles = $urandom_range(0, 3) != 0;
			count = $urandom_range(10, 150);
			send_pixels(count, cov_pct, edge_pct);
			items += count;
		end
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Result side: random ready gaps, with the long hold-off on request.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned gap;
		wait (arst_n);
		forever begin
			gap = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
			if (ready_hold_cycles != 0) begin
				gap = ready_hold_cycles;
				ready_hold_cycles = 0;
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!out_ready) begin
				out_ready <= 1'b1;
			end
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Every result transfer is compared with the oldest tile still queued.
	always @(posedge clk) begin : tile_checker
		tile_result_t want;
		tile_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.col  = tile_col;
			got.row  = tile_row;
			got.rate = rate_t'(rate_code);
			got.last = last_tile;
			if (expected_tiles.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected tile: col %0d row %0d rate %0d last %0d",
						got.col, got.row, got.rate, got.last);
			end else begin
				want = expected_tiles.pop_front();
				if (got.col !== want.col || got.row !== want.row ||
					got.rate !== want.rate || got.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"tile mismatch: expected col %0d row %0d rate %0d last %0d,",
							" got col %0d row %0d rate %0d last %0d"},
							want.col, want.row, want.rate, want.last,
							got.col, got.row, got.rate, got.last);
				end
			end
		end
	end

	// Ends the run if no transfer happens on any channel for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("shading_rate_tile_classifier_tb NOT OK");
		$finish;
	end

	initial begin : test_sequence
		// Reset register values of the block: 1920x1080, 85% dense, 3% edges.
		width_reg  = CFG_W'(1920);
		height_reg = CFG_W'(1080);
		dense_reg  = PCT_W'(85);
		edge_reg   = PCT_W'(3);
		restart_frame();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_size_limits();
		test_threshold_extremes();
		test_unknown_index();
		test_output_backpressure();
		test_random_frames();
		settle();

		if (mismatch_count == 0 && expected_tiles.size() == 0)
			$display("shading_rate_tile_classifier_tb OK");
		else
			$display("shading_rate_tile_classifier_tb NOT OK");
		$finish;
	end

endmodule
